// ===== sv/kcrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcrc_pkg: shared types, constants and helpers
// Widths, register codes and the mod-96 reduction used by the cipher core.
// ----------------------------------------------------------------------------
package kcrc_pkg;

	localparam int unsigned GEN_W  = 17;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned PROD_W = 24;
	localparam int unsigned POS_W  = 7;

	localparam logic [GEN_W-1:0]  KEY_RESET   = 17'd1;
	localparam logic [GEN_W-1:0]  GEN_MOD     = 17'd65537;
	localparam logic [PROD_W-1:0] LEHMER_MULT = 24'd75;
	localparam logic [BYTE_W-1:0] WIN_LOW     = 8'd32;
	localparam logic [BYTE_W-1:0] WIN_SIZE    = 8'd96;

	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t CFG_KEY = 1'b0;
	localparam cfg_idx_t CFG_DIR = 1'b1;

	localparam logic DIR_ENCRYPT = 1'b0;
	localparam logic DIR_DECRYPT = 1'b1;

	typedef struct packed {
		logic             load;
		logic             step;
		logic [GEN_W-1:0] key;
	} gen_ctl_t;

	// Printable window 32..127
	function automatic logic in_window(input logic [BYTE_W-1:0] b);
		in_window = (b[7] == 1'b0) && (b[6:5] != 2'b00);
	endfunction

	// v mod 96 = ((v >> 5) mod 3) * 32 + v[4:0]; mod 3 by base-4 digit sum
	function automatic logic [POS_W-1:0] mod96(input logic [GEN_W-1:0] v);
		logic [4:0] dsum;
		logic [1:0] m3;
		dsum = 5'(v[6:5]) + 5'(v[8:7]) + 5'(v[10:9]) + 5'(v[12:11])
			+ 5'(v[14:13]) + 5'(v[16:15]);
		if (dsum >= 5'd12) dsum = dsum - 5'd12;
		if (dsum >= 5'd6)  dsum = dsum - 5'd6;
		if (dsum >= 5'd3)  dsum = dsum - 5'd3;
		m3 = dsum[1:0];
		mod96 = {m3, v[4:0]};
	endfunction

endpackage
`default_nettype wire

// ===== sv/kcrc_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcrc_ifs: channel interfaces
// Byte request channel, byte result channel and register write channel.
// ----------------------------------------------------------------------------
interface kcrc_in_if;
	logic                        valid;
	logic                        ready;
	logic [kcrc_pkg::BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface kcrc_out_if;
	logic                        valid;
	logic                        ready;
	logic [kcrc_pkg::BYTE_W-1:0] out_byte;

	modport source (output valid, output out_byte, input ready);
	modport sink   (input valid, input out_byte, output ready);
endinterface

interface kcrc_cfg_if;
	logic                       valid;
	logic                       ready;
	kcrc_pkg::cfg_idx_t         index;
	logic [kcrc_pkg::GEN_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/kcrc_lehmer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcrc_lehmer: keystream generator
// Holds the generator value; steps value*75 mod 65537 by subtract-and-fold.
// ----------------------------------------------------------------------------
module kcrc_lehmer (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire kcrc_pkg::gen_ctl_t     ctl,
	output logic [kcrc_pkg::GEN_W-1:0]  gen_value,
	output logic [kcrc_pkg::GEN_W-1:0]  gen_next
);

	logic [kcrc_pkg::GEN_W-1:0]  gen_q;
	logic [kcrc_pkg::PROD_W-1:0] prod;
	logic [15:0]                 low;
	logic [7:0]                  high;

	always_comb begin
		prod = {7'd0, gen_q} * kcrc_pkg::LEHMER_MULT;
		low  = prod[15:0];
		high = prod[23:16];
		// fold: 2^16 = -1 mod 65537, add the modulus back on borrow
		if (low >= {8'd0, high}) begin
			gen_next = {1'b0, low} - {9'd0, high};
		end else begin
			gen_next = {1'b0, low} + kcrc_pkg::GEN_MOD - {9'd0, high};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= kcrc_pkg::KEY_RESET;
		end else if (ctl.load) begin
			gen_q <= ctl.key;
		end else if (ctl.step) begin
			gen_q <= gen_next;
		end
	end

	assign gen_value = gen_q;

endmodule
`default_nettype wire

// ===== sv/kcrc_rotate.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcrc_rotate: window rotation
// Rotates a printable byte by (generator mod 96), forward or backward.
// ----------------------------------------------------------------------------
module kcrc_rotate (
	input  wire  [kcrc_pkg::BYTE_W-1:0] in_byte,
	input  wire  [kcrc_pkg::GEN_W-1:0]  gen,
	input  wire                         dir,
	output logic [kcrc_pkg::BYTE_W-1:0] out_byte
);

	logic [kcrc_pkg::POS_W-1:0]  rot;
	logic [kcrc_pkg::POS_W-1:0]  pos;
	logic [kcrc_pkg::BYTE_W-1:0] sum;

	always_comb begin
		rot = kcrc_pkg::mod96(gen);
		pos = in_byte[6:0] - kcrc_pkg::WIN_LOW[6:0];
		if (dir == kcrc_pkg::DIR_DECRYPT) begin
			sum = {1'b0, pos} + kcrc_pkg::WIN_SIZE - {1'b0, rot};
		end else begin
			sum = {1'b0, pos} + {1'b0, rot};
		end
		if (sum >= kcrc_pkg::WIN_SIZE) sum = sum - kcrc_pkg::WIN_SIZE;
		if (kcrc_pkg::in_window(in_byte)) begin
			out_byte = sum + kcrc_pkg::WIN_LOW;
		end else begin
			out_byte = in_byte;
		end
	end

endmodule
`default_nettype wire

// ===== sv/keystream_char_rotation_cipher_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keystream_char_rotation_cipher_core: byte stream cipher
// Lehmer keystream (x75 mod 65537) rotating bytes 32..127 by keystream mod 96.
// ----------------------------------------------------------------------------
//  channel  role    fields            handshake
//  cfg      sink    index, data[16:0] valid/ready, ready always high
//  item     sink    in_byte[7:0]      valid/ready
//  result   source  out_byte[7:0]     valid/ready
//
// One byte per cycle sustained while results are taken; a request is held
// in s1, then in the result register. The generator steps in the cycle a
// request is taken, then the rotation runs between those two registers.
// Reset sets key 1, encrypt, generator 1. A key write reloads the generator.
// A stalled result holds; s1 keeps accepting until it is full too.
// ----------------------------------------------------------------------------
module keystream_char_rotation_cipher_core (
	input  wire         clk,
	input  wire         arst_n,
	kcrc_cfg_if.sink    cfg,
	kcrc_in_if.sink     item,
	kcrc_out_if.source  result
);

	logic                        dir_q;
	logic                        v_s1;
	logic [kcrc_pkg::BYTE_W-1:0] byte_s1;
	logic [kcrc_pkg::GEN_W-1:0]  gen_s1;
	logic                        out_v_q;
	logic [kcrc_pkg::BYTE_W-1:0] out_byte_q;

	logic                        cfg_wr;
	logic                        key_wr;
	logic                        accept;
	logic                        out_free;
	logic                        s1_free;
	kcrc_pkg::gen_ctl_t          gen_ctl;
	logic [kcrc_pkg::GEN_W-1:0]  gen_value;
	logic [kcrc_pkg::GEN_W-1:0]  gen_next;
	logic [kcrc_pkg::BYTE_W-1:0] rot_byte;
	logic                        win_s1;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	always_comb begin
		key_wr = 1'b0;
		unique case (cfg.index)
			kcrc_pkg::CFG_KEY: key_wr = cfg_wr;
			kcrc_pkg::CFG_DIR: key_wr = 1'b0;
			default:           key_wr = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= kcrc_pkg::DIR_ENCRYPT;
		end else if (cfg_wr) begin
			unique case (cfg.index)
				// key goes straight into the generator
				kcrc_pkg::CFG_KEY: ;
				kcrc_pkg::CFG_DIR: dir_q <= cfg.data[0];
				default:           ;
			endcase
		end
	end

	// handshake: result register drains, s1 refills behind it
	assign out_free   = !out_v_q || result.ready;
	assign s1_free    = !v_s1 || out_free;
	assign item.ready = s1_free;
	assign accept     = item.valid && item.ready;

	assign gen_ctl.load = key_wr;
	assign gen_ctl.step = accept;
	assign gen_ctl.key  = cfg.data;

	kcrc_lehmer u_lehmer (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (gen_ctl),
		.gen_value (gen_value),
		.gen_next  (gen_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= item.in_byte;
			gen_s1  <= gen_next;
		end
	end

	kcrc_rotate u_rotate (
		.in_byte  (byte_s1),
		.gen      (gen_s1),
		.dir      (dir_q),
		.out_byte (rot_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s1) begin
			out_byte_q <= rot_byte;
		end
	end

	assign result.valid    = out_v_q;
	assign result.out_byte = out_byte_q;

	assign win_s1 = kcrc_pkg::in_window(byte_s1);

	// key write reloads the generator
	a_key_reload: assert property (@(posedge clk) disable iff (!arst_n)
		key_wr |=> (gen_value == $past(cfg.data)))
		else $error("generator not reloaded by key write");

	// every step leaves the generator below the modulus
	a_gen_range: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !key_wr) |=> (gen_value <= 17'd65536))
		else $error("generator out of range after step");

	// bytes outside the window pass through untouched
	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && out_free && !win_s1) |=> (result.out_byte == $past(byte_s1)))
		else $error("non-printable byte altered");

	// a taken request always lands in s1
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted request lost");

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: self-checking bench for keystream_char_rotation_cipher_core
// Drives byte requests and register writes with random gaps and result
// stalls, predicts every output byte from its own copy of the Lehmer
// generator and rotation, and compares results in order.
// ----------------------------------------------------------------------------
module testbench;

	typedef logic [kcrc_pkg::GEN_W-1:0]  gen_t;
	typedef logic [kcrc_pkg::BYTE_W-1:0] byte_t;
	typedef logic [kcrc_pkg::PROD_W-1:0] prod_t;

	logic clk;
	logic arst_n;

	kcrc_cfg_if cfg_ch();
	kcrc_in_if  in_ch();
	kcrc_out_if out_ch();

	keystream_char_rotation_cipher_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (in_ch),
		.result (out_ch)
	);

	// predictor state
	gen_t gen_state;
	gen_t key_reg;
	logic dir_reg;

	byte_t pending_bytes[$];
	byte_t expected_bytes[$];

	logic        item_fire;
	logic        calm;
	int unsigned send_gap;
	int unsigned stall_left;
	int unsigned mismatches;
	int unsigned queued_total;
	int unsigned rotated_seen;
	int unsigned passed_seen;
	int unsigned results_seen;
	int unsigned settings_seen;

	always #2 clk = ~clk;

	// Advance the generator, then rotate within the printable window.
	function automatic byte_t cipher_byte(input byte_t b);
		prod_t       product;
		logic [15:0] low;
		logic [7:0]  high;
		gen_t        next;
		int unsigned rot;
		int unsigned pos;
		product = prod_t'(gen_state) * kcrc_pkg::LEHMER_MULT;
		low = product[15:0];
		high = product[23:16];
		if (low >= 16'(high))
			next = gen_t'(low - 16'(high));
		else
			next = gen_t'(low) + kcrc_pkg::GEN_MOD - gen_t'(high);
		gen_state = next;
		rot = int'(next) % 96;
		if (b < 8'd32 || b >= 8'd128)
			return b;
		pos = int'(b) - 32;
		if (dir_reg == kcrc_pkg::DIR_ENCRYPT)
			pos = (pos + rot) % 96;
		else
			pos = (pos + 96 - rot) % 96;
		return byte_t'(pos + 32);
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 15);
		if (r == 0)
			return $urandom_range(20, 40);
		if (r < 9)
			return 0;
		return $urandom_range(1, 3);
	endfunction

	task automatic report_mismatch(input string what, input byte_t got, input byte_t want);
		$display("%0t: mismatch %s: got %h want %h", $time, what, got, want);
		mismatches++;
	endtask

	// request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_ch.valid || item_fire) begin
				if (send_gap > 0) begin
					in_ch.valid <= 1'b0;
					send_gap--;
				end else if (pending_bytes.size() > 0) begin
					in_ch.valid <= 1'b1;
					in_ch.in_byte <= pending_bytes.pop_front();
					send_gap = pick_gap();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result backpressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		byte_t want;
		if (arst_n) begin
			item_fire <= in_ch.valid && in_ch.ready;
			if (cfg_ch.valid && cfg_ch.ready) begin
				if (cfg_ch.index == kcrc_pkg::CFG_KEY) begin
					key_reg = cfg_ch.data;
					gen_state = cfg_ch.data;
				end else if (cfg_ch.index == kcrc_pkg::CFG_DIR) begin
					dir_reg = cfg_ch.data[0];
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.in_byte >= 8'd32 && in_ch.in_byte < 8'd128)
					rotated_seen++;
				else
					passed_seen++;
				expected_bytes.push_back(cipher_byte(in_ch.in_byte));
			end
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (expected_bytes.size() == 0) begin
					report_mismatch("unexpected result", out_ch.out_byte, 8'h00);
				end else begin
					want = expected_bytes.pop_front();
					if (out_ch.out_byte !== want)
						report_mismatch("out_byte", out_ch.out_byte, want);
				end
			end
		end
	end

	task automatic write_register(input kcrc_pkg::cfg_idx_t idx, input gen_t value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic queue_byte(input byte_t b);
		pending_bytes.push_back(b);
		queued_total++;
	endtask

	// Hold until every request is in and every result is out.
	task automatic settle();
		while (pending_bytes.size() != 0 || in_ch.valid || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic gen_t pick_key();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 4))
				0: return 17'd0;
				1: return 17'd1;
				2: return 17'd65536;
				3: return 17'd65537;
				default: return 17'h1FFFF;
			endcase
		end
		if (r == 1)
			return gen_t'($urandom_range(65538, 131071));
		return gen_t'($urandom_range(1, 65536));
	endfunction

	initial begin
		int unsigned n;
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.in_byte = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = kcrc_pkg::CFG_KEY;
		cfg_ch.data = '0;
		item_fire = 1'b0;
		calm = 1'b0;
		send_gap = 0;
		stall_left = 0;
		mismatches = 0;
		queued_total = 0;
		rotated_seen = 0;
		passed_seen = 0;
		results_seen = 0;
		settings_seen = 1;
		key_reg = kcrc_pkg::KEY_RESET;
		gen_state = kcrc_pkg::KEY_RESET;
		dir_reg = kcrc_pkg::DIR_ENCRYPT;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// reset defaults: window edges, control and high bytes
		queue_byte(8'h00); queue_byte(8'h1F); queue_byte(8'h20); queue_byte(8'h7F);
		queue_byte(8'h80); queue_byte(8'hFF); queue_byte(8'h41); queue_byte(8'h5A);
		settle();

		write_register(kcrc_pkg::CFG_DIR, 17'(kcrc_pkg::DIR_DECRYPT));
		write_register(kcrc_pkg::CFG_KEY, 17'd65536);
		settings_seen++;
		queue_byte(8'h20); queue_byte(8'h7F); queue_byte(8'h30);
		queue_byte(8'h00); queue_byte(8'hFF);
		settle();

		// zero key: generator stuck at zero
		write_register(kcrc_pkg::CFG_KEY, 17'd0);
		settings_seen++;
		queue_byte(8'h20); queue_byte(8'h7F); queue_byte(8'h55);
		settle();

		write_register(kcrc_pkg::CFG_KEY, 17'd65537);
		settings_seen++;
		queue_byte(8'h41); queue_byte(8'h7F);
		settle();

		// key above the modulus, then flip direction without a reload
		write_register(kcrc_pkg::CFG_KEY, 17'h1FFFF);
		write_register(kcrc_pkg::CFG_DIR, 17'(kcrc_pkg::DIR_ENCRYPT));
		settings_seen++;
		queue_byte(8'h20); queue_byte(8'h7F);
		settle();
		write_register(kcrc_pkg::CFG_DIR, 17'(kcrc_pkg::DIR_DECRYPT));
		settings_seen++;
		queue_byte(8'hFF); queue_byte(8'h61);
		settle();

		while (queued_total < 620) begin
			if ($urandom_range(0, 3) != 0)
				write_register(kcrc_pkg::CFG_KEY, pick_key());
			if ($urandom_range(0, 3) != 0)
				write_register(kcrc_pkg::CFG_DIR, 17'($urandom_range(0, 1)));
			settings_seen++;
			calm = ($urandom_range(0, 3) == 0);
			n = $urandom_range(10, 60);
			repeat (n) begin
				if ($urandom_range(0, 9) < 7)
					queue_byte(8'($urandom_range(32, 127)));
				else
					queue_byte(8'($urandom_range(0, 255)));
			end
			settle();
		end
		calm = 1'b0;
		settle();

		if (expected_bytes.size() != 0)
			report_mismatch("results missing", 8'h00, expected_bytes[0]);
		$display("covered %0d bytes (%0d rotated, %0d passed through), %0d results",
			queued_total, rotated_seen, passed_seen, results_seen);
		$display("over %0d register settings including zero and out-of-range keys",
			settings_seen);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
sv/kcrc_pkg.sv
sv/kcrc_ifs.sv
sv/kcrc_lehmer.sv
sv/kcrc_rotate.sv
sv/keystream_char_rotation_cipher_core.sv
tb/sv/testbench.sv
